>>> src/pif_pkg.sv
// ----------------------------------------------------------------------------
// pif_pkg: shared types and constants of the point-in-figure tester
// Request/result words, figure kinds and the back-end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package pif_pkg;

  localparam int unsigned MaxFiguresDef = 16;
  localparam int unsigned CoordBits     = 24;
  localparam int unsigned PointNumBits  = 16;
  localparam int unsigned FigNumBits    = 5;
  localparam int unsigned CmdDepth      = 2;

  typedef enum logic [1:0] {
    KindRect = 2'd0,
    KindTri  = 2'd1,
    KindCirc = 2'd2,
    KindNone = 2'd3
  } kind_e;

  typedef enum logic {
    ReqAdd   = 1'b0,
    ReqQuery = 1'b1
  } req_e;

  typedef struct packed {
    logic                        req_type;
    logic [1:0]                  figure_kind;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
  } req_t;

  typedef struct packed {
    logic [PointNumBits-1:0] point_number;
    logic [FigNumBits-1:0]   figure_number;
    logic                    found;
    logic                    last;
  } res_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkRead,
    BkProd,
    BkSum,
    BkTest,
    BkEmit,
    BkMiss
  } bk_state_e;

endpackage

`default_nettype wire

>>> src/pif_ram.sv
// ----------------------------------------------------------------------------
// pif_ram: generic single-port-write, single-port-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pif_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/pif_front.sv
// ----------------------------------------------------------------------------
// pif_front: request intake
// Sorts rectangle corners, writes figures into the table, queues queries.
// ----------------------------------------------------------------------------
`default_nettype none

module pif_front import pif_pkg::*; #(
  parameter int unsigned MaxFigures = MaxFiguresDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire req_t                          req_i,
  output logic                               full_o,
  // figure table write
  output logic                               fig_we_o,
  output logic [$clog2(MaxFigures+1)-1:0]    fig_cnt_o,
  output logic [1:0]                         fig_kind_o,
  output logic [6*CoordBits-1:0]             fig_coords_o,
  // query queue toward back
  output logic                               q_valid_o,
  output logic [2*CoordBits-1:0]             q_point_o,
  output logic [$clog2(MaxFigures+1)-1:0]    q_cnt_o,
  input  wire logic                          q_take_i
);

  localparam int unsigned CntBits = $clog2(MaxFigures+1);
  localparam int unsigned PtrBits = $clog2(CmdDepth);
  localparam int unsigned EntBits = CntBits + 2*CoordBits;

  logic [CntBits-1:0] cnt_q;
  // each queued query keeps the figure count it saw when taken
  logic [EntBits-1:0] fifo_q [CmdDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   used_q;

  logic signed [CoordBits-1:0] v [6];
  logic accept, is_query, add_ok, do_push;

  always_comb begin
    v[0] = req_i.ax;
    v[1] = req_i.ay;
    v[2] = req_i.bx;
    v[3] = req_i.by;
    v[4] = req_i.cx;
    v[5] = req_i.cy;
  end

  assign full_o   = (used_q == (PtrBits+1)'(CmdDepth));
  assign accept   = push_i && !full_o;
  assign is_query = (req_i.req_type == ReqQuery);
  assign add_ok   = (cnt_q < CntBits'(MaxFigures)) && (req_i.figure_kind != KindNone);
  assign do_push  = accept && is_query;

  assign fig_we_o   = accept && !is_query && add_ok;
  assign fig_cnt_o  = cnt_q;
  assign fig_kind_o = req_i.figure_kind;

  // rectangle corners go in sorted as lo, hi
  always_comb begin
    fig_coords_o = {v[5], v[4], v[3], v[2], v[1], v[0]};
    if (req_i.figure_kind == KindRect) begin
      fig_coords_o = {v[5], v[4],
                      (v[1] < v[3]) ? v[3] : v[1],
                      (v[0] < v[2]) ? v[2] : v[0],
                      (v[1] < v[3]) ? v[1] : v[3],
                      (v[0] < v[2]) ? v[0] : v[2]};
    end
  end

  assign q_valid_o = (used_q != '0);
  assign q_point_o = fifo_q[rd_q][2*CoordBits-1:0];
  assign q_cnt_o   = fifo_q[rd_q][EntBits-1 -: CntBits];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_q] <= {cnt_q, v[1], v[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wr_q   <= '0;
      rd_q   <= '0;
      used_q <= '0;
    end else begin
      if (fig_we_o) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (q_take_i) begin
        rd_q <= rd_q + 1'b1;
      end
      used_q <= used_q + (PtrBits+1)'(do_push) - (PtrBits+1)'(q_take_i);
    end
  end

endmodule

`default_nettype wire

>>> src/pif_back.sv
// ----------------------------------------------------------------------------
// pif_back: query engine
// Walks the figure table one figure at a time and emits hits, or a miss word when none.
// ----------------------------------------------------------------------------
`default_nettype none

module pif_back import pif_pkg::*; #(
  parameter int unsigned MaxFigures = MaxFiguresDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire logic [2*CoordBits-1:0]        q_point_i,
  input  wire logic [$clog2(MaxFigures+1)-1:0] q_cnt_i,
  output logic                               q_take_o,
  output logic [$clog2(MaxFigures)-1:0]      raddr_o,
  input  wire logic [1:0]                    rd_kind_i,
  input  wire logic [6*CoordBits-1:0]        rd_coords_i,
  output logic                               empty_o,
  output res_t                               res_o,
  input  wire logic                          pop_i
);

  localparam int unsigned CntBits = $clog2(MaxFigures+1);
  localparam int unsigned IdxBits = $clog2(MaxFigures);
  localparam int unsigned DBits   = CoordBits + 2;     // coordinate differences
  localparam int unsigned PBits   = 2*DBits;           // one product
  localparam int unsigned SBits   = PBits + 2;         // sums of products

  bk_state_e state_q, state_d;

  logic signed [CoordBits-1:0] px_q, py_q;
  logic [CntBits-1:0]  idx_q;      // next figure to test
  logic [CntBits-1:0]  fcnt_q;     // figures stored when the query was taken
  logic                last_fig;
  logic [PointNumBits-1:0] pnum_q;
  logic                hit_any_q;
  logic [1:0]          kind_q;
  logic signed [CoordBits-1:0] f [6];
  logic signed [DBits-1:0] d1, d2, d3, d4, d5, d6;
  logic signed [PBits-1:0] p_q [6];
  logic signed [SBits-1:0] s_a_q, s_b_q, s_c_q, s_d_q;
  logic signed [CoordBits-1:0] lo_x, lo_y;
  logic rect_hit_q, hit_q, hit;

  // output register
  logic  out_full_q;
  res_t  out_q;
  logic  out_load;

  assign raddr_o  = idx_q[IdxBits-1:0];
  assign empty_o  = !out_full_q;
  assign res_o    = out_q;
  assign last_fig = (CntBits'(idx_q + 1'b1) == fcnt_q);

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      f[i] = rd_coords_i[i*CoordBits +: CoordBits];
    end
  end

  // differences feeding the multipliers, chosen by the kind read this cycle
  always_comb begin
    d1 = '0; d2 = '0; d3 = '0; d4 = '0; d5 = '0; d6 = '0;
    case (rd_kind_i)
      KindTri: begin
        d1 = DBits'(f[3]) - DBits'(f[5]);   // y1-y2
        d2 = DBits'(f[4]) - DBits'(f[2]);   // x2-x1
        d3 = DBits'(f[5]) - DBits'(f[1]);   // y2-y0
        d4 = DBits'(f[0]) - DBits'(f[4]);   // x0-x2
        d5 = DBits'(px_q) - DBits'(f[4]);   // px-x2
        d6 = DBits'(py_q) - DBits'(f[5]);   // py-y2
      end
      KindCirc: begin
        d1 = DBits'(px_q) - DBits'(f[0]);
        d2 = DBits'(py_q) - DBits'(f[1]);
        d3 = DBits'(f[2]);
      end
      default: begin
      end
    endcase
  end

  // hit test per kind: triangle sign tests on the registered sums
  logic signed [SBits-1:0] ta, tb, tc, td;
  always_comb begin
    ta = s_a_q; tb = s_b_q; td = s_d_q;
    tc = s_d_q - s_a_q - s_b_q;
    if (s_d_q < 0) begin
      ta = -s_a_q; tb = -s_b_q; tc = -tc; td = -s_d_q;
    end
    case (kind_q)
      KindRect: hit = rect_hit_q;
      KindTri:  hit = (s_d_q != 0) && !ta[SBits-1] && !tb[SBits-1] && !tc[SBits-1]
                      && !(td < ta) && !(td < tb) && !(td < tc);
      KindCirc: hit = (s_a_q < s_b_q);
      default:  hit = 1'b0;
    endcase
  end

  assign lo_x = f[0];
  assign lo_y = f[1];

  logic emit_ok;
  assign emit_ok = !out_full_q || pop_i;

  always_comb begin
    state_d  = state_q;
    q_take_o = 1'b0;
    case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          q_take_o = 1'b1;
          state_d  = (q_cnt_i == '0) ? BkMiss : BkRead;
        end
      end
      BkRead:  state_d = BkProd;
      BkProd:  state_d = BkSum;
      BkSum:   state_d = BkTest;
      BkTest: begin
        if (hit) begin
          state_d = BkEmit;
        end else if (last_fig) begin
          state_d = hit_any_q ? BkEmit : BkMiss;
        end else begin
          state_d = BkRead;
        end
      end
      BkEmit: begin
        // a hit is held until the next one is known, so last can be set
        if (idx_q == fcnt_q && !hit_q) begin
          if (emit_ok) state_d = BkIdle;
        end else if (emit_ok) begin
          state_d = (idx_q == fcnt_q) ? BkEmit : BkRead;
        end
      end
      BkMiss: begin
        if (emit_ok) state_d = BkIdle;
      end
      default: state_d = BkIdle;
    endcase
  end

  // a pending hit (pend_q, pend_fig_q) waits for the next test; emit it when the next
  // hit shows up or the walk ends
  logic [FigNumBits-1:0] pend_fig_q;
  logic pend_q;
  logic emit_now, emit_last;

  always_comb begin
    emit_now  = 1'b0;
    emit_last = 1'b0;
    if (state_q == BkMiss && emit_ok) begin
      emit_now = 1'b1; emit_last = 1'b1;
    end
  end

  always_comb begin
    out_load = 1'b0;
    if (state_q == BkEmit && emit_ok) begin
      out_load = !hit_q || pend_q;
    end
    if (emit_now) begin
      out_load = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BkIdle && q_valid_i) begin
      px_q   <= q_point_i[CoordBits-1:0];
      py_q   <= q_point_i[2*CoordBits-1:CoordBits];
      fcnt_q <= q_cnt_i;
    end
    if (state_q == BkProd) begin
      kind_q <= rd_kind_i;
      if (rd_kind_i == KindCirc) begin
        p_q[0] <= PBits'(d1 * d1);
        p_q[1] <= PBits'(d2 * d2);
        p_q[2] <= PBits'(d3 * d3);
      end else begin
        p_q[0] <= PBits'(d1 * d4);   // (y1-y2)(x0-x2)
        p_q[1] <= PBits'(d2 * d3);
        p_q[2] <= PBits'(d1 * d5);
        p_q[3] <= PBits'(d2 * d6);
        p_q[4] <= PBits'(d3 * d5);
        p_q[5] <= PBits'(d4 * d6);
      end
      rect_hit_q <= (lo_x < px_q) && (px_q < f[2]) && (lo_y < py_q) && (py_q < f[3]);
    end
    if (state_q == BkSum) begin
      if (kind_q == KindCirc) begin
        s_a_q <= SBits'(p_q[0]) + SBits'(p_q[1]);
        s_b_q <= SBits'(p_q[2]);
      end else begin
        s_a_q <= SBits'(p_q[2]) + SBits'(p_q[3]);
        s_b_q <= SBits'(p_q[4]) + SBits'(p_q[5]);
        // p_q[1] holds (x2-x1)(y2-y0), the negated second term of d
        s_d_q <= SBits'(p_q[0]) - SBits'(p_q[1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BkIdle;
      idx_q      <= '0;
      pnum_q     <= PointNumBits'(1);
      hit_any_q  <= 1'b0;
      hit_q      <= 1'b0;
      pend_q     <= 1'b0;
      pend_fig_q <= '0;
      out_full_q <= 1'b0;
      out_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_full_q <= 1'b1;
      end else if (pop_i && out_full_q) begin
        out_full_q <= 1'b0;
      end
      case (state_q)
        BkIdle: begin
          idx_q     <= '0;
          hit_any_q <= 1'b0;
          pend_q    <= 1'b0;
        end
        BkTest: begin
          idx_q <= idx_q + 1'b1;
          hit_q <= hit;
          if (hit) hit_any_q <= 1'b1;
        end
        BkEmit: begin
          if (emit_ok) begin
            // flush the previous pending hit if a new one arrived
            if (pend_q && hit_q) begin
              out_q <= '{pnum_q, pend_fig_q, 1'b1, 1'b0};
            end
            if (hit_q) begin
              pend_q     <= 1'b1;
              pend_fig_q <= FigNumBits'(idx_q);
              hit_q      <= 1'b0;
            end else begin
              // walk is over, pending hit is the last one
              out_q  <= '{pnum_q, pend_fig_q, 1'b1, 1'b1};
              pend_q <= 1'b0;
              pnum_q <= (pnum_q == '1) ? PointNumBits'(1) : pnum_q + 1'b1;
            end
          end
        end
        BkMiss: begin
          if (emit_now) begin
            out_q  <= '{pnum_q, FigNumBits'(0), 1'b0, emit_last};
            pnum_q <= (pnum_q == '1) ? PointNumBits'(1) : pnum_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/point_in_figure_tester.sv
// ----------------------------------------------------------------------------
// point_in_figure_tester: figure table with point containment queries
//
//   channel | handshake          | word
//   --------+--------------------+-------------------------------
//   request | push / full        | req_t: add figure or query point
//   result  | pop / empty        | res_t: point, figure, found, last
//
// An add is written into the table in the cycle it is taken. A query walks
// the figures stored when it was taken, each through the read, multiply,
// sum and test steps; hits and the closing word leave through the emit or miss state.
// A full result register holds the walk until pop.
// Reset empties the table and sets the point number to 1. A two-entry
// query queue lets adds and queries arrive while the walk runs.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_figure_tester import pif_pkg::*; #(
  parameter int unsigned MaxFigures = MaxFiguresDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic      full,
  input  wire req_t req_i,
  output logic      empty,
  input  wire logic pop,
  output res_t      res_o
);

  localparam int unsigned CntBits = $clog2(MaxFigures+1);
  localparam int unsigned IdxBits = $clog2(MaxFigures);
  localparam int unsigned RamW    = 6*CoordBits + 2;

  logic                    fig_we, q_valid, q_take;
  logic [CntBits-1:0]      fig_cnt, q_cnt;
  logic [1:0]              fig_kind;
  logic [6*CoordBits-1:0]  fig_coords;
  logic [2*CoordBits-1:0]  q_point;
  logic [IdxBits-1:0]      raddr;
  logic [RamW-1:0]         rdata;

  pif_front #(.MaxFigures(MaxFigures)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .req_i, .full_o(full),
    .fig_we_o(fig_we), .fig_cnt_o(fig_cnt), .fig_kind_o(fig_kind),
    .fig_coords_o(fig_coords),
    .q_valid_o(q_valid), .q_point_o(q_point), .q_cnt_o(q_cnt), .q_take_i(q_take)
  );

  pif_ram #(.Width(RamW), .Depth(MaxFigures)) u_table (
    .clk_i,
    .we_i(fig_we), .waddr_i(fig_cnt[IdxBits-1:0]),
    .wdata_i({fig_kind, fig_coords}),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  pif_back #(.MaxFigures(MaxFigures)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_point_i(q_point), .q_cnt_i(q_cnt), .q_take_o(q_take),
    .raddr_o(raddr),
    .rd_kind_i(rdata[RamW-1 -: 2]), .rd_coords_i(rdata[6*CoordBits-1:0]),
    .empty_o(empty), .res_o, .pop_i(pop)
  );

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for point_in_figure_tester
// A directed table of adds and queries, then random query points probed
// against the now full figure table, checked against a behavioral
// containment predictor with random idling on both queue sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb import pif_pkg::*; ();

  localparam int unsigned NumFig = MaxFiguresDef;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  req_t req_i = '0;
  res_t res_o;

  point_in_figure_tester i_dut (
    .clk_i, .rst_ni, .push, .full, .req_i, .empty, .pop, .res_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("[point_in_figure_tester] ERROR");
    $finish;
  end

  // predictor state
  kind_e          tab_kind [NumFig];
  longint         tab_crd  [NumFig][6];
  int unsigned    tab_count;
  logic [15:0]    next_point;
  res_t           exp_words[$];
  int unsigned    n_errors;
  bit             sender_quiet;   // last part of the run: no idling

  task automatic report(input string what, input res_t got, input res_t want);
    n_errors++;
    $display("mismatch %s: got pt=%0d fig=%0d f=%0b l=%0b want pt=%0d fig=%0d f=%0b l=%0b",
             what, got.point_number, got.figure_number, got.found, got.last,
             want.point_number, want.figure_number, want.found, want.last);
  endtask

  function automatic bit hit_tri(longint f[6], longint px, longint py);
    longint d, a, b, c;
    d = (f[3]-f[5])*(f[0]-f[4]) + (f[4]-f[2])*(f[1]-f[5]);
    a = (f[3]-f[5])*(px-f[4]) + (f[4]-f[2])*(py-f[5]);
    b = (f[5]-f[1])*(px-f[4]) + (f[0]-f[4])*(py-f[5]);
    if (d == 0) return 1'b0;
    c = d - a - b;
    if (d < 0) begin
      d = -d; a = -a; b = -b; c = -c;
    end
    return a >= 0 && b >= 0 && c >= 0 && a <= d && b <= d && c <= d;
  endfunction

  // appends the words one request makes to exp_words and updates the figure table
  task automatic predict_request(input req_t r);
    longint v[6];
    longint f[6];
    longint dx, dy;
    bit hit;
    int n;
    res_t w;
    v = '{r.ax, r.ay, r.bx, r.by, r.cx, r.cy};
    if (r.req_type == ReqAdd) begin
      if (tab_count >= NumFig || r.figure_kind == KindNone) return;
      f = '{default: 0};
      case (kind_e'(r.figure_kind))
        KindRect: begin
          f[0] = v[0] < v[2] ? v[0] : v[2];  f[2] = v[0] < v[2] ? v[2] : v[0];
          f[1] = v[1] < v[3] ? v[1] : v[3];  f[3] = v[1] < v[3] ? v[3] : v[1];
        end
        KindTri: f = v;
        default: begin
          f[0] = v[0]; f[1] = v[1]; f[2] = v[2];
        end
      endcase
      tab_kind[tab_count] = kind_e'(r.figure_kind);
      tab_crd[tab_count] = f;
      tab_count++;
      return;
    end
    n = 0;
    for (int i = 0; i < tab_count; i++) begin
      f = tab_crd[i];
      case (tab_kind[i])
        KindRect: hit = f[0] < v[0] && v[0] < f[2] && f[1] < v[1] && v[1] < f[3];
        KindTri:  hit = hit_tri(f, v[0], v[1]);
        default: begin
          dx = v[0] - f[0];
          dy = v[1] - f[1];
          // dx*dx+dy*dy fits 64 bits unsigned; compare as unsigned
          hit = ($unsigned(dx*dx) + $unsigned(dy*dy)) < $unsigned(f[2]*f[2]);
        end
      endcase
      if (hit) begin
        w = '{point_number: next_point, figure_number: 5'(i + 1), found: 1'b1,
              last: 1'b0};
        exp_words = {exp_words, w};
        n++;
      end
    end
    if (n == 0) begin
      w = '{point_number: next_point, figure_number: '0, found: 1'b0, last: 1'b1};
      exp_words = {exp_words, w};
    end else begin
      exp_words[$].last = 1'b1;
    end
    next_point = (next_point == 16'hFFFF) ? 16'd1 : next_point + 16'd1;
  endtask

  // pushes one word, sometimes with a random gap before it
  task automatic send_word(input req_t r);
    int gap;
    if (!sender_quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_request(r);
  endtask

  // result side: checks every accepted word
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (exp_words.size() == 0) begin
        report("unexpected word", res_o, '0);
      end else begin
        if (res_o !== exp_words[0]) report("field", res_o, exp_words[0]);
        void'(exp_words.pop_front());
      end
    end
  end

  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (!sender_quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 18) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic req_t mk(input req_e t, input kind_e k, input int a0, input int a1,
                              input int b0, input int b1, input int c0, input int c1);
    req_t r;
    r.req_type = t;
    r.figure_kind = k;
    r.ax = CoordBits'(a0); r.ay = CoordBits'(a1);
    r.bx = CoordBits'(b0); r.by = CoordBits'(b1);
    r.cx = CoordBits'(c0); r.cy = CoordBits'(c1);
    return r;
  endfunction

  function automatic int rnd_coord(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  localparam int CMax = 8388607;
  localparam int CMin = -8388608;

  typedef struct {
    req_t r;
    bit   chk;     // typed-in expectation present
    res_t want;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    stim_row_t s;
    req_t r;
    int nfig, nq, span, px, py;
    tab_count = 0;
    next_point = 16'd1;
    n_errors = 0;
    sender_quiet = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    s.chk = 1'b1;
    s.r = mk(ReqQuery, KindRect, 0, 0, 0, 0, 0, 0);           // empty table
    s.want = '{16'd1, 5'd0, 1'b0, 1'b1}; rows = {rows, s};
    s.chk = 1'b0;
    s.r = mk(ReqAdd, KindRect, 2560, 2560, -2560, -2560, 0, 0); rows = {rows, s};
    s.r = mk(ReqAdd, KindTri, 0, 0, 2560, 0, 0, 2560); rows = {rows, s};
    s.r = mk(ReqAdd, KindCirc, 0, 0, -1280, 0, 0, 0); rows = {rows, s};
    s.r = mk(ReqAdd, KindTri, 5, 5, 10, 10, 15, 15); rows = {rows, s};  // degenerate
    s.r = mk(ReqAdd, KindNone, 0, 0, 1, 1, 0, 0); rows = {rows, s};     // ignored
    s.r = mk(ReqAdd, KindRect, CMin, CMin, CMax, CMax, CMin, CMax); rows = {rows, s};
    s.r = mk(ReqAdd, KindCirc, CMax, CMin, CMin, 0, CMax, CMax); rows = {rows, s};
    s.r = mk(ReqQuery, KindNone, 0, 0, CMax, CMin, -1, -1); rows = {rows, s};
    s.r = mk(ReqQuery, KindRect, 2560, 0, 0, 0, 0, 0); rows = {rows, s};  // on edges
    s.r = mk(ReqQuery, KindRect, 1280, 1280, 0, 0, 0, 0); rows = {rows, s};
    s.r = mk(ReqQuery, KindRect, 10, 10, 0, 0, 0, 0); rows = {rows, s};
    s.r = mk(ReqQuery, KindRect, 1280, 0, 0, 0, 0, 0); rows = {rows, s};
    s.r = mk(ReqQuery, KindRect, CMax, CMax, 0, 0, 0, 0); rows = {rows, s};
    s.r = mk(ReqQuery, KindRect, CMin, CMin, 0, 0, 0, 0); rows = {rows, s};
    s.r = mk(ReqQuery, KindRect, CMax, CMin, 0, 0, 0, 0); rows = {rows, s};
    for (int i = 0; i < 12; i++) begin
      s.r = mk(ReqAdd, kind_e'(i % 3), -100*i, -100, 100*i+50, 300, 0, 400);
      rows = {rows, s};
    end
    s.r = mk(ReqQuery, KindRect, 1, 1, 0, 0, 0, 0); rows = {rows, s};
    foreach (rows[i]) begin
      send_word(rows[i].r);
      if (rows[i].chk) begin
        if (exp_words[$] !== rows[i].want) report("typed", exp_words[$], rows[i].want);
        push <= 1'b0;
        wait (exp_words.size() == 0);
        @(posedge clk_i);
      end
    end

    // random: the table is full from here, so further adds are ignored
    for (int k = 0; k < 450; k++) begin
      if (k == 200) begin
        // sender holds off until every word has drained
        push <= 1'b0;
        wait (exp_words.size() == 0);
        repeat (3) @(posedge clk_i);
      end
      if (k == 380) sender_quiet = 1'b1;
      span = ($urandom_range(0, 9) == 0) ? CMax : 700;
      if ($urandom_range(0, 9) == 0) begin
        r = mk(ReqAdd, kind_e'($urandom_range(0, 3)), int'($urandom), int'($urandom),
               int'($urandom), int'($urandom), int'($urandom), int'($urandom));
      end else begin
        px = rnd_coord(span); py = rnd_coord(span);
        r = mk(ReqQuery, kind_e'($urandom_range(0, 3)), px, py,
               int'($urandom), int'($urandom), int'($urandom), int'($urandom));
        if ($urandom_range(0, 15) == 0) r.ax = CoordBits'($urandom);
      end
      send_word(r);
    end
    push <= 1'b0;
    wait (exp_words.size() == 0);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("[point_in_figure_tester] OK");
    end else begin
      $display("[point_in_figure_tester] ERROR");
    end
    $finish;
  end
endmodule
